[rtl/core/cpio_pkg.sv]
// ----------------------------------------------------------------------------
// cpio_pkg
// Types, codes and lookup functions shared by the cpio newc walker.
// ----------------------------------------------------------------------------
package cpio_pkg;

    localparam int CPIO_NAME_MAX = 32;

    localparam int HDR_LAST    = 109;
    localparam int FSIZE_FIRST = 54;
    localparam int NSIZE_FIRST = 94;
    localparam int FIELD_DIGITS = 8;
    localparam int MAGIC_LEN   = 6;
    localparam int TRAILER_LEN = 10;
    localparam int TARGET_MAX  = 32;

    // configuration register indexes
    localparam logic [2:0] CFG_WALK_MODE     = 3'd0;
    localparam logic [2:0] CFG_TARGET_0      = 3'd1;
    localparam logic [2:0] CFG_TARGET_1      = 3'd2;
    localparam logic [2:0] CFG_TARGET_2      = 3'd3;
    localparam logic [2:0] CFG_TARGET_3      = 3'd4;
    localparam logic [2:0] CFG_TARGET_LENGTH = 3'd5;

    typedef enum logic [2:0] {
        EV_SIZE      = 3'd0,
        EV_CHAR      = 3'd1,
        EV_FILE      = 3'd2,
        EV_TRAILER   = 3'd3,
        EV_BAD_MAGIC = 3'd4,
        EV_NOT_FOUND = 3'd5
    } t_event;

    typedef struct packed {
        logic [7:0] archive_byte;
        logic       restart;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [7:0]  char_value;
        logic [31:0] entry_size;
        logic        name_truncated;
        logic        last;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic   accept;
        logic   restart;
        logic   adv_align;
        logic   hdr_step;
        logic   ld_name;
        logic   name_step;
        logic   ld_data;
        logic   data_step;
        logic   clr_header;
        logic   out_load;
        t_event out_ev;
        logic   run_start;
        logic   run_adv;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic mode;
        logic magic_bad;
        logic hdr_done;
        logic nsize_zero;
        logic fin;
        logic fin_trailer;
        logic rem_one;
        logic fsize_zero;
        logic align_wrap;
        logic tm_next;
        logic run_empty;
        logic run_last;
    } t_dp_status;

    function automatic logic [7:0] magic_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd1:    ch = "7";
            3'd3:    ch = "7";
            3'd5:    ch = "1";
            default: ch = "0";
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] trailer_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = "T";
            4'd1:    ch = "R";
            4'd2:    ch = "A";
            4'd3:    ch = "I";
            4'd4:    ch = "L";
            4'd5:    ch = "E";
            4'd6:    ch = "R";
            default: ch = "!";
        endcase
        return ch;
    endfunction

    // non-hex digits count as zero
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= "0" && c <= "9") v = 4'(c - "0");
        else if (c >= "a" && c <= "f") v = 4'(c - "a" + 8'd10);
        else if (c >= "A" && c <= "F") v = 4'(c - "A" + 8'd10);
        return v;
    endfunction

endpackage

[rtl/core/cpio_dp.sv]
// ----------------------------------------------------------------------------
// cpio_dp
// Walker datapath: header counters, size parse, name buffer and matching,
// configuration registers and the output register.
// ----------------------------------------------------------------------------
module cpio_dp import cpio_pkg::*; #(
    parameter int NAME_MAX = CPIO_NAME_MAX
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in_item   i_in_data,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_data
);

    localparam int IW  = $clog2(NAME_MAX);
    localparam int NCW = $clog2(NAME_MAX + 1);

    logic         r_mode;
    logic [255:0] r_target;
    logic [5:0]   r_tlen;

    logic [6:0]   r_hc, e_hc, n_hc;
    logic [31:0]  r_ns, e_ns, n_ns;
    logic [31:0]  r_fs, e_fs, n_fs;
    logic [31:0]  r_rem, e_rem, n_rem;
    logic [1:0]   r_align, e_align, n_align;
    logic [NCW-1:0] r_nc, e_nc, n_nc;
    logic         r_tm, e_tm, n_tm;
    logic         r_trm, e_trm, n_trm;
    logic         r_ne, e_ne, n_ne;
    logic         r_run_trunc, n_run_trunc;
    logic [IW-1:0] r_rd_ptr, n_rd_ptr;
    logic [7:0]   r_rd_data;
    logic [7:0]   mem [NAME_MAX];

    logic         r_out_valid;
    t_out_item    r_out;
    logic         out_free;

    logic [7:0]   c;
    logic [31:0]  p, f_len;
    logic         add, tgt_ok, trl_ok, tm_a, trm_a, f_tm, f_trm, fin_n, fin_h;
    logic         fin_trunc, tm_fin, wr_en, run_last;
    logic [NCW-1:0] nc_a;
    logic [7:0]   tchar;

    assign c = i_in_data.archive_byte;

    // apply restart to the walk state before the byte is used
    always_comb begin
        e_hc    = i_cmd.restart ? '0 : r_hc;
        e_ns    = i_cmd.restart ? '0 : r_ns;
        e_fs    = i_cmd.restart ? '0 : r_fs;
        e_rem   = i_cmd.restart ? '0 : r_rem;
        e_align = i_cmd.restart ? '0 : r_align;
        e_nc    = i_cmd.restart ? '0 : r_nc;
        e_tm    = i_cmd.restart ? 1'b1 : r_tm;
        e_trm   = i_cmd.restart ? 1'b1 : r_trm;
        e_ne    = i_cmd.restart ? 1'b0 : r_ne;
    end

    // name character checks
    assign p      = r_ns - r_rem;
    assign tchar  = r_target[{p[4:0], 3'b000} +: 8];
    assign add    = !r_ne && (c != 8'd0);
    assign tgt_ok = (p < 32'(TARGET_MAX)) && (p < {26'd0, r_tlen}) && (c == tchar);
    assign trl_ok = (p < 32'(TRAILER_LEN)) && (c == trailer_char(p[3:0]));
    assign tm_a   = r_tm && !(add && !tgt_ok);
    assign trm_a  = r_trm && !(add && !trl_ok);
    assign wr_en  = i_cmd.name_step && add && (p < 32'(NAME_MAX));
    assign nc_a   = wr_en ? NCW'(p) + NCW'(1) : r_nc;
    assign fin_n  = !r_ne && ((c == 8'd0) || (r_rem == 32'd1));
    assign fin_h  = i_cmd.ld_name && (n_ns == 32'd0);

    // decide the name: zero-length name at header end, or in the name phase
    always_comb begin
        if (i_cmd.name_step) begin
            f_len = (c == 8'd0) ? p : r_ns;
            f_tm  = tm_a;
            f_trm = trm_a;
        end else begin
            f_len = 32'd0;
            f_tm  = 1'b1;
            f_trm = 1'b1;
        end
    end
    assign fin_trunc = f_len > 32'(NAME_MAX);
    assign tm_fin    = r_mode && f_tm && (f_len == {26'd0, r_tlen});

    // next walk state
    always_comb begin
        n_hc = e_hc;
        n_ns = e_ns;
        n_fs = e_fs;
        n_rem = e_rem;
        n_align = e_align;
        n_nc = e_nc;
        n_tm = e_tm;
        n_trm = e_trm;
        n_ne = e_ne;
        n_run_trunc = r_run_trunc;
        if (i_cmd.adv_align) n_align = e_align + 2'd1;
        if (i_cmd.hdr_step) begin
            if (e_hc >= 7'(FSIZE_FIRST) && e_hc < 7'(FSIZE_FIRST + FIELD_DIGITS))
                n_fs = {e_fs[27:0], hex_value(c)};
            if (e_hc >= 7'(NSIZE_FIRST) && e_hc < 7'(NSIZE_FIRST + FIELD_DIGITS))
                n_ns = {e_ns[27:0], hex_value(c)};
            n_hc = e_hc + 7'd1;
        end
        if (i_cmd.ld_name) begin
            n_rem = n_ns;
            n_nc  = '0;
            n_tm  = fin_h ? tm_fin : 1'b1;
            n_trm = 1'b1;
            n_ne  = fin_h;
            if (fin_h) n_run_trunc = fin_trunc;
        end
        if (i_cmd.name_step) begin
            n_rem = r_rem - 32'd1;
            n_nc  = nc_a;
            n_trm = trm_a;
            n_tm  = fin_n ? tm_fin : tm_a;
            n_ne  = r_ne || fin_n;
            if (fin_n) n_run_trunc = fin_trunc;
        end
        if (i_cmd.data_step) n_rem = e_rem - 32'd1;
        if (i_cmd.ld_data) n_rem = n_fs;
        if (i_cmd.clr_header) begin
            n_hc = '0;
            n_ns = '0;
            n_fs = '0;
        end
    end

    // hold walk state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hc <= '0;
            r_ns <= '0;
            r_fs <= '0;
            r_rem <= '0;
            r_align <= '0;
            r_nc <= '0;
            r_tm <= 1'b1;
            r_trm <= 1'b1;
            r_ne <= 1'b0;
            r_run_trunc <= 1'b0;
        end else if (i_cmd.accept) begin
            r_hc <= n_hc;
            r_ns <= n_ns;
            r_fs <= n_fs;
            r_rem <= n_rem;
            r_align <= n_align;
            r_nc <= n_nc;
            r_tm <= n_tm;
            r_trm <= n_trm;
            r_ne <= n_ne;
            r_run_trunc <= n_run_trunc;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_target <= '0;
            r_tlen <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WALK_MODE:     r_mode <= i_cfg_data[0];
                CFG_TARGET_0:      r_target[63:0] <= i_cfg_data;
                CFG_TARGET_1:      r_target[127:64] <= i_cfg_data;
                CFG_TARGET_2:      r_target[191:128] <= i_cfg_data;
                CFG_TARGET_3:      r_target[255:192] <= i_cfg_data;
                CFG_TARGET_LENGTH: r_tlen <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // name buffer: one write port, one registered read with write bypass
    always_comb begin
        n_rd_ptr = r_rd_ptr;
        if (i_cmd.run_start) n_rd_ptr = '0;
        else if (i_cmd.run_adv) n_rd_ptr = r_rd_ptr + IW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[p[IW-1:0]] <= c;
        if (wr_en && (p[IW-1:0] == n_rd_ptr)) r_rd_data <= c;
        else r_rd_data <= mem[n_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_rd_ptr <= '0;
        else r_rd_ptr <= n_rd_ptr;
    end

    assign run_last = (NCW'(r_rd_ptr) + NCW'(1)) == r_nc;

    // output register
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_valid <= 1'b0;
        else if (i_cmd.out_load) r_out_valid <= 1'b1;
        else if (out_free) r_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.event_res      <= i_cmd.out_ev;
            r_out.char_value     <= 8'd0;
            r_out.entry_size     <= 32'd0;
            r_out.name_truncated <= 1'b0;
            r_out.last           <= 1'b0;
            case (i_cmd.out_ev)
                EV_SIZE: begin
                    r_out.entry_size     <= e_fs;
                    r_out.name_truncated <= fin_trunc;
                end
                EV_CHAR: begin
                    r_out.char_value     <= r_rd_data;
                    r_out.name_truncated <= r_run_trunc;
                    r_out.last           <= run_last;
                end
                EV_FILE: begin
                    r_out.char_value <= c;
                    r_out.last       <= (e_rem == 32'd1);
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // status
    always_comb begin
        o_status.out_free    = out_free;
        o_status.mode        = r_mode;
        o_status.magic_bad   = (e_hc < 7'(MAGIC_LEN)) && (c != magic_char(e_hc[2:0]));
        o_status.hdr_done    = (e_hc == 7'(HDR_LAST));
        o_status.nsize_zero  = (n_ns == 32'd0);
        o_status.fin         = fin_n;
        o_status.fin_trailer = f_trm && (f_len == 32'(TRAILER_LEN));
        o_status.rem_one     = (e_rem == 32'd1);
        o_status.fsize_zero  = (e_fs == 32'd0);
        o_status.align_wrap  = (e_align == 2'd3);
        o_status.tm_next     = n_tm;
        o_status.run_empty   = (n_nc == '0);
        o_status.run_last    = run_last;
    end

endmodule

[rtl/core/cpio_ctrl.sv]
// ----------------------------------------------------------------------------
// cpio_ctrl
// Walker controller: archive phase sequencing and name run emission.
// ----------------------------------------------------------------------------
module cpio_ctrl import cpio_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_restart,
    output logic       o_in_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [6:0] {
        S_HEADER = 7'b0000001,
        S_NAME   = 7'b0000010,
        S_NPAD   = 7'b0000100,
        S_DATA   = 7'b0001000,
        S_DPAD   = 7'b0010000,
        S_DONE   = 7'b0100000,
        S_EMIT   = 7'b1000000
    } t_state;

    t_state r_state, n_state, r_ret, n_ret, es, ph;
    t_state de_st, sd_st, nbd_st;
    logic   accept, de_clr, sd_clr, nbd_clr, nbd_ld, run;

    assign o_in_stall = (r_state == S_EMIT) || !i_status.out_free;
    assign accept     = i_in_valid && !o_in_stall;
    assign es         = (accept && i_restart) ? S_HEADER : r_state;

    // end-of-data, start-of-data and end-of-name follow-ups
    always_comb begin
        de_clr = !i_status.tm_next && i_status.align_wrap;
        de_st  = i_status.tm_next ? S_DONE : (i_status.align_wrap ? S_HEADER : S_DPAD);
        sd_st  = i_status.fsize_zero ? de_st : S_DATA;
        sd_clr = i_status.fsize_zero && de_clr;
        nbd_st = i_status.align_wrap ? sd_st : S_NPAD;
        nbd_ld = i_status.align_wrap;
        nbd_clr = i_status.align_wrap && sd_clr;
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.out_ev = EV_SIZE;
        o_cmd.accept = accept;
        o_cmd.restart = accept && i_restart;
        n_state = r_state;
        n_ret = r_ret;
        ph = r_state;
        run = 1'b0;
        if (r_state == S_EMIT) begin
            // drain the buffered name, one character per free output slot
            if (i_status.out_free) begin
                o_cmd.out_load = 1'b1;
                o_cmd.out_ev   = EV_CHAR;
                o_cmd.run_adv  = 1'b1;
                if (i_status.run_last) n_state = r_ret;
            end
        end else if (accept) begin
            o_cmd.adv_align = (es != S_DONE);
            case (es)
                S_HEADER: begin
                    o_cmd.hdr_step = 1'b1;
                    if (i_status.magic_bad) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_ev   = EV_BAD_MAGIC;
                        n_state = S_DONE;
                    end else if (i_status.hdr_done) begin
                        o_cmd.ld_name = 1'b1;
                        if (i_status.nsize_zero) begin
                            if (!i_status.mode) o_cmd.out_load = 1'b1;
                            o_cmd.ld_data = nbd_ld;
                            o_cmd.clr_header = nbd_clr;
                            n_state = nbd_st;
                        end else begin
                            n_state = S_NAME;
                        end
                    end else begin
                        n_state = S_HEADER;
                    end
                end
                S_NAME: begin
                    o_cmd.name_step = 1'b1;
                    if (i_status.fin && i_status.fin_trailer) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_ev = i_status.mode ? EV_NOT_FOUND : EV_TRAILER;
                        n_state = S_DONE;
                    end else begin
                        ph = S_NAME;
                        if (i_status.fin && !i_status.mode) begin
                            o_cmd.out_load = 1'b1;
                            run = !i_status.run_empty;
                        end
                        if (i_status.rem_one) begin
                            ph = nbd_st;
                            o_cmd.ld_data = nbd_ld;
                            o_cmd.clr_header = nbd_clr;
                        end
                        o_cmd.run_start = run;
                        if (run) begin
                            n_state = S_EMIT;
                            n_ret = ph;
                        end else begin
                            n_state = ph;
                        end
                    end
                end
                S_NPAD: begin
                    if (i_status.align_wrap) begin
                        o_cmd.ld_data = 1'b1;
                        o_cmd.clr_header = sd_clr;
                        n_state = sd_st;
                    end
                end
                S_DATA: begin
                    o_cmd.data_step = 1'b1;
                    if (i_status.tm_next) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_ev = EV_FILE;
                    end
                    if (i_status.rem_one) begin
                        o_cmd.clr_header = de_clr;
                        n_state = de_st;
                    end
                end
                S_DPAD: begin
                    if (i_status.align_wrap) begin
                        o_cmd.clr_header = 1'b1;
                        n_state = S_HEADER;
                    end
                end
                default: n_state = S_DONE;
            endcase
        end
    end

    // advance the controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HEADER;
            r_ret <= S_HEADER;
        end else begin
            r_state <= n_state;
            r_ret <= n_ret;
        end
    end

    // a stopped walk stays stopped until a restart byte
    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && accept && !i_restart) |=> (r_state == S_DONE))
        else $error("walk left the stopped state without a restart");

    // a result is only loaded into a free output register
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_status.out_free)
        else $error("result loaded over a pending result");

    // a name run starts only from the name phase
    a_emit_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_EMIT && n_state == S_EMIT) |-> (r_state == S_NAME))
        else $error("name run entered outside the name phase");

    // input is never taken while a name run drains
    a_no_accept_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> !o_cmd.hdr_step && !o_cmd.name_step && !o_cmd.data_step)
        else $error("archive byte consumed during a name run");

endmodule

[rtl/core/cpio_newc_archive_walker_top.sv]
// Size, file and status results are registered in the cycle after their byte is taken.
// Throughput: one archive byte per cycle unless stalled; a listed name stalls the input
// while its buffered characters drain through the single read port of the name buffer.
// A stalled output register stalls the input for as long as it is held.
// Reset: synchronous, active low; clears walk and configuration state, name buffer
// contents stay undefined until written.
// ----------------------------------------------------------------------------
// cpio_newc_archive_walker_top
// Walks a cpio newc archive byte stream, listing entries or finding one file.
// ----------------------------------------------------------------------------
module cpio_newc_archive_walker_top import cpio_pkg::*; #(
    parameter int NAME_MAX = CPIO_NAME_MAX
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // phase sequencing
    cpio_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_restart  (i_in_data.restart),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // counters, name buffer and output register
    cpio_dp #(
        .NAME_MAX (NAME_MAX)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
